/* hdl/itaf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter package
// Shared types, character codes and the digit table of the formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    // Largest number of characters that one item produces.
    localparam logic [6:0] MAX_CHARS = 7'd64;

    // Codes of the base_select field.
    localparam logic [1:0] BSEL_OCT = 2'd0;
    localparam logic [1:0] BSEL_DEC = 2'd1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_NONE  = 8'h00;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef logic [6:0] count_t;

    typedef enum logic [1:0] {
        BASE_OCT = 2'd0,
        BASE_DEC = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_COUNT,
        BK_PLAN,
        BK_EMIT
    } back_state_t;

    // Classified item as it travels from the front to the back.
    typedef struct packed {
        base_t       base;
        logic [7:0]  sign_ch;
        logic        has_sign;
        logic [1:0]  pfx_len;
        count_t      width;
        logic [5:0]  prec;
        logic        left;
        logic        zpad;
        logic        lc;
    } desc_t;

    // Setting bit 5 turns an upper-case letter into lower case; digits already have it.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lc);
        digit_char = HEX_DIGITS[d] | {2'b00, lc, 5'b00000};
    endfunction

endpackage

/* hdl/itaf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts items, takes the magnitude and sorts out sign, prefix and limits.
// ----------------------------------------------------------------------------
module itaf_front
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   item_valid,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             base_select,
    input  logic [6:0]             min_width,
    input  logic [5:0]             min_digits,
    input  logic                   signed_mode,
    input  logic                   left_justify,
    input  logic                   zero_pad,
    input  logic                   plus_sign,
    input  logic                   space_sign,
    input  logic                   alt_prefix,
    input  logic                   lower_case,
    input  logic                   queue_full,
    output logic                   push,
    output desc_t                  push_desc,
    output logic [VALUE_WIDTH-1:0] push_mag
);

    logic       negative;
    base_t      base;
    logic [1:0] fixed_len;
    logic [6:0] prec_limit;

    assign negative = signed_mode && value[VALUE_WIDTH-1];
    assign push     = item_valid && !queue_full;
    assign push_mag = negative ? (~value + VALUE_WIDTH'(1)) : value;

    always_comb
    begin
        unique case (base_select)
            BSEL_OCT: base = BASE_OCT;
            BSEL_DEC: base = BASE_DEC;
            default:  base = BASE_HEX;
        endcase
    end

    always_comb
    begin
        push_desc.base = base;
        push_desc.lc   = lower_case;
        push_desc.left = left_justify;
        push_desc.zpad = zero_pad && !left_justify;

        priority if (negative)
            push_desc.sign_ch = CH_MINUS;
        else if (signed_mode && plus_sign)
            push_desc.sign_ch = CH_PLUS;
        else if (signed_mode && space_sign)
            push_desc.sign_ch = CH_SPACE;
        else
            push_desc.sign_ch = CH_NONE;
        push_desc.has_sign = (push_desc.sign_ch != CH_NONE);

        if (alt_prefix && base == BASE_HEX)
            push_desc.pfx_len = 2'd2;
        else if (alt_prefix && base == BASE_OCT)
            push_desc.pfx_len = 2'd1;
        else
            push_desc.pfx_len = 2'd0;

        push_desc.width = (min_width > MAX_CHARS) ? MAX_CHARS : min_width;

        // Sign, prefix and precision zeros together never pass the character limit.
        fixed_len  = {1'b0, push_desc.has_sign} + push_desc.pfx_len;
        prec_limit = MAX_CHARS - {5'b0, fixed_len};
        push_desc.prec = ({1'b0, min_digits} > prec_limit) ? prec_limit[5:0] : min_digits;
    end

endmodule

/* hdl/itaf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter item queue
// Two-entry queue that decouples the front end from the character engine.
// ----------------------------------------------------------------------------
module itaf_queue
    import itaf_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/itaf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter character engine
// Converts the magnitude to digits, lays out the field and emits characters.
// ----------------------------------------------------------------------------
module itaf_back
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  desc_t                  q_desc,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    output logic                   q_pop,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [7:0]             out_char,
    output logic                   last_char
);

    localparam int NDIG   = (VALUE_WIDTH + 2) / 3;
    localparam int STEPS  = (VALUE_WIDTH + 3) / 4;
    localparam int BIN_W  = 4 * STEPS;
    localparam int OCT_W  = 3 * NDIG;
    localparam int HEX_W  = 4 * NDIG;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int ND_W   = $clog2(NDIG + 1);
    localparam int STEP_W = $clog2(STEPS);

    back_state_t       state_reg, state_next;
    desc_t             desc_reg, desc_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [3:0]        digit_reg [NDIG];
    logic [3:0]        digit_next [NDIG];
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ND_W-1:0]   nd_reg, nd_next;
    count_t            lead_reg, lead_next;
    count_t            pfx_start_reg, pfx_start_next;
    count_t            zero_start_reg, zero_start_next;
    count_t            dig_start_reg, dig_start_next;
    count_t            trail_start_reg, trail_start_next;
    count_t            last_pos_reg, last_pos_next;
    count_t            pos_reg, pos_next;
    logic              char_valid_reg, char_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              last_char_reg, last_char_next;

    logic [OCT_W-1:0]  oct_ext;
    logic [HEX_W-1:0]  hex_ext;
    logic [3:0]        dab_dig [NDIG];
    logic [3:0]        dab_adj [NDIG];
    logic [BIN_W-1:0]  dab_bin;
    logic [ND_W-1:0]   nd_calc;
    count_t            nd_ext, fixed_len, prec_eff, content, pad, lead, zp, trail;
    count_t            pfx_start, zero_start, dig_start, trail_start;
    count_t            digit_pos;
    logic [7:0]        emit_char;
    logic              emit_load;

    assign oct_ext = OCT_W'(q_mag);
    assign hex_ext = HEX_W'(q_mag);

    // Four double-dabble steps per cycle: add three to every digit of five or more,
    // then shift one binary bit into the BCD digits.
    always_comb
    begin
        dab_dig = digit_reg;
        dab_bin = bin_reg;
        dab_adj = digit_reg;
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                dab_adj[i] = (dab_dig[i] >= 4'd5) ? dab_dig[i] + 4'd3 : dab_dig[i];
            end
            dab_dig[0] = {dab_adj[0][2:0], dab_bin[BIN_W-1]};
            for (int i = 1; i < NDIG; i++)
            begin
                dab_dig[i] = {dab_adj[i][2:0], dab_adj[i-1][3]};
            end
            dab_bin = {dab_bin[BIN_W-2:0], 1'b0};
        end
    end

    // Count of significant digits; a zero value still shows one digit.
    always_comb
    begin
        nd_calc = ND_W'(1);
        for (int i = 0; i < NDIG; i++)
        begin
            if (digit_reg[i] != 4'd0)
            begin
                nd_calc = ND_W'(i + 1);
            end
        end
    end

    // Field layout, all in character positions from the start of the run.
    always_comb
    begin
        nd_ext      = count_t'(nd_reg);
        fixed_len   = count_t'(desc_reg.has_sign) + count_t'(desc_reg.pfx_len);
        prec_eff    = (count_t'(desc_reg.prec) > nd_ext) ? count_t'(desc_reg.prec) : nd_ext;
        content     = fixed_len + prec_eff;
        pad         = (desc_reg.width > content) ? desc_reg.width - content : '0;
        lead        = (!desc_reg.left && !desc_reg.zpad) ? pad : '0;
        zp          = desc_reg.zpad ? pad : '0;
        trail       = desc_reg.left ? pad : '0;
        pfx_start   = lead + count_t'(desc_reg.has_sign);
        zero_start  = pfx_start + count_t'(desc_reg.pfx_len);
        dig_start   = zero_start + zp + (prec_eff - nd_ext);
        trail_start = dig_start + nd_ext;
    end

    always_comb
    begin
        digit_pos = trail_start_reg - count_t'(1) - pos_reg;
        priority if (pos_reg < lead_reg)
            emit_char = CH_SPACE;
        else if (pos_reg < pfx_start_reg)
            emit_char = desc_reg.sign_ch;
        else if (pos_reg < zero_start_reg)
            emit_char = (pos_reg == pfx_start_reg) ? CH_ZERO
                                                   : (CH_X | {2'b00, desc_reg.lc, 5'b00000});
        else if (pos_reg < dig_start_reg)
            emit_char = CH_ZERO;
        else if (pos_reg < trail_start_reg)
            emit_char = digit_char(digit_reg[digit_pos[IDX_W-1:0]], desc_reg.lc);
        else
            emit_char = CH_SPACE;
    end

    assign emit_load = (state_reg == BK_EMIT) && (!char_valid_reg || !char_stall);
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;

    always_comb
    begin
        state_next       = state_reg;
        desc_next        = desc_reg;
        bin_next         = bin_reg;
        digit_next       = digit_reg;
        step_next        = step_reg;
        nd_next          = nd_reg;
        lead_next        = lead_reg;
        pfx_start_next   = pfx_start_reg;
        zero_start_next  = zero_start_reg;
        dig_start_next   = dig_start_reg;
        trail_start_next = trail_start_reg;
        last_pos_next    = last_pos_reg;
        pos_next         = pos_reg;
        out_char_next    = out_char_reg;
        last_char_next   = last_char_reg;
        char_valid_next  = char_valid_reg && char_stall;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    desc_next = q_desc;
                    bin_next  = BIN_W'(q_mag);
                    step_next = STEP_W'(STEPS - 1);
                    for (int i = 0; i < NDIG; i++)
                    begin
                        unique case (q_desc.base)
                            BASE_DEC: digit_next[i] = 4'd0;
                            BASE_OCT: digit_next[i] = {1'b0, oct_ext[3*i +: 3]};
                            default:  digit_next[i] = hex_ext[4*i +: 4];
                        endcase
                    end
                    state_next = (q_desc.base == BASE_DEC) ? BK_CONV : BK_COUNT;
                end
            end
            BK_CONV:
            begin
                digit_next = dab_dig;
                bin_next   = dab_bin;
                step_next  = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = BK_COUNT;
                end
            end
            BK_COUNT:
            begin
                nd_next    = nd_calc;
                state_next = BK_PLAN;
            end
            BK_PLAN:
            begin
                lead_next        = lead;
                pfx_start_next   = pfx_start;
                zero_start_next  = zero_start;
                dig_start_next   = dig_start;
                trail_start_next = trail_start;
                last_pos_next    = trail_start + trail - count_t'(1);
                pos_next         = '0;
                state_next       = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (emit_load)
                begin
                    char_valid_next = 1'b1;
                    out_char_next   = emit_char;
                    last_char_next  = (pos_reg == last_pos_reg);
                    pos_next        = pos_reg + count_t'(1);
                    if (pos_reg == last_pos_reg)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg        <= desc_next;
        bin_reg         <= bin_next;
        digit_reg       <= digit_next;
        step_reg        <= step_next;
        nd_reg          <= nd_next;
        lead_reg        <= lead_next;
        pfx_start_reg   <= pfx_start_next;
        zero_start_reg  <= zero_start_next;
        dig_start_reg   <= dig_start_next;
        trail_start_reg <= trail_start_next;
        last_pos_reg    <= last_pos_next;
        pos_reg         <= pos_next;
        out_char_reg    <= out_char_next;
        last_char_reg   <= last_char_next;
    end

    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;

endmodule

/* hdl/integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter
// Formats one integer per item as printf-style text, one character per beat.
// ----------------------------------------------------------------------------
// Each item yields from 1 to 64 character beats, the last one flagged by
// last_char. The character engine handles one item at a time: an octal or
// hex item is loaded and then passes through the count and plan states
// before its characters are emitted; a decimal item runs the binary-to-BCD
// converter, which shifts four bits per cycle, before those same states. A
// two-entry queue lets the input side take two further items while a run
// is being emitted, and the output register lets the engine start the next
// item while the final character waits.
module integer_to_ascii_formatter
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             base_select,
    input  logic [6:0]             min_width,
    input  logic [5:0]             min_digits,
    input  logic                   signed_mode,
    input  logic                   left_justify,
    input  logic                   zero_pad,
    input  logic                   plus_sign,
    input  logic                   space_sign,
    input  logic                   alt_prefix,
    input  logic                   lower_case,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [7:0]             out_char,
    output logic                   last_char
);

    localparam int DATA_W = VALUE_WIDTH + $bits(desc_t);

    logic                   queue_full;
    logic                   push;
    desc_t                  push_desc;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic                   q_valid;
    logic                   q_pop;
    logic [DATA_W-1:0]      q_data;
    desc_t                  q_desc;
    logic [VALUE_WIDTH-1:0] q_mag;

    assign item_stall = queue_full;
    assign q_desc     = q_data[DATA_W-1:VALUE_WIDTH];
    assign q_mag      = q_data[VALUE_WIDTH-1:0];

    itaf_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .item_valid   (item_valid),
        .value        (value),
        .base_select  (base_select),
        .min_width    (min_width),
        .min_digits   (min_digits),
        .signed_mode  (signed_mode),
        .left_justify (left_justify),
        .zero_pad     (zero_pad),
        .plus_sign    (plus_sign),
        .space_sign   (space_sign),
        .alt_prefix   (alt_prefix),
        .lower_case   (lower_case),
        .queue_full   (queue_full),
        .push         (push),
        .push_desc    (push_desc),
        .push_mag     (push_mag)
    );

    itaf_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_desc, push_mag}),
        .pop       (q_pop),
        .full      (queue_full),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    itaf_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_desc     (q_desc),
        .q_mag      (q_mag),
        .q_pop      (q_pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

/* hdl/itaf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Formatter port checker
// Watches the ports of the formatter for run length, character set and beats.
// ----------------------------------------------------------------------------
module itaf_checker
    import itaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_stall,
    input  logic       char_valid,
    input  logic       char_stall,
    input  logic [7:0] out_char,
    input  logic       last_char
);

    logic       item_beat;
    logic       char_beat;
    logic [5:0] run_cnt_reg, run_cnt_next;
    logic [2:0] pending_reg, pending_next;

    assign item_beat = item_valid && !item_stall;
    assign char_beat = char_valid && !char_stall;

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (char_beat)
        begin
            run_cnt_next = last_char ? 6'd0 : run_cnt_reg + 6'd1;
        end
        pending_next = pending_reg + {2'b00, item_beat} - {2'b00, char_beat && last_char};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= 6'd0;
            pending_reg <= 3'd0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
            pending_reg <= pending_next;
        end
    end

    // A character shows up only for an item that was taken earlier.
    a_no_orphan_char: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> pending_reg != 3'd0)
        else $error("character beat without an outstanding item");

    // No run is longer than the character limit.
    a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (char_beat && run_cnt_reg == 6'd63) |-> last_char)
        else $error("character run longer than the limit");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (out_char >= CH_SPACE && out_char <= 8'h78))
        else $error("character outside the formatter's set");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=> (char_valid && $stable(out_char) && $stable(last_char)))
        else $error("stalled character beat changed");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last_char  (last_char)
);

/* tb/itaf_char_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter character checker
// Watches both channels of the formatter. Each accepted item is turned into
// the text it should print. Each character beat is compared with that text
// in order. Mismatch and leftover counts go to the test top.
// ----------------------------------------------------------------------------
module itaf_char_checker
    import itaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             base_select,
    input  logic [6:0]             min_width,
    input  logic [5:0]             min_digits,
    input  logic                   signed_mode,
    input  logic                   left_justify,
    input  logic                   zero_pad,
    input  logic                   plus_sign,
    input  logic                   space_sign,
    input  logic                   alt_prefix,
    input  logic                   lower_case,
    input  logic                   char_valid,
    input  logic                   char_stall,
    input  logic [7:0]             out_char,
    input  logic                   last_char,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    char_beat_t expected_text [$];

    // Builds the printed text of one item and queues it, one entry per character.
    function automatic void format_item(
        input logic [63:0] raw,
        input logic [1:0]  bsel,
        input logic [6:0]  fw,
        input logic [5:0]  md,
        input logic        sgn,
        input logic        left,
        input logic        zpad_in,
        input logic        plus,
        input logic        space,
        input logic        alt,
        input logic        lower
    );
        logic [63:0] vmask;
        logic [63:0] num;
        logic [63:0] radix;
        logic [7:0]  lc;
        logic [7:0]  sign_ch;
        logic [7:0]  digs [64];
        logic [7:0]  text [$];
        logic        zpad;
        int          nd;
        int          fixed;
        int          pfx;
        int          width;
        int          prec;
        int          pad;
        int          n;
        char_beat_t  beat;

        vmask   = {64{1'b1}} >> (64 - VALUE_WIDTH);
        num     = raw & vmask;
        radix   = (bsel == BSEL_OCT) ? 64'd8 : (bsel == BSEL_DEC) ? 64'd10 : 64'd16;
        lc      = lower ? 8'h20 : 8'h00;
        zpad    = zpad_in && !left;
        sign_ch = CH_NONE;
        fixed   = 0;
        pfx     = 0;
        nd      = 0;

        if (sgn)
        begin
            if (num[VALUE_WIDTH-1])
            begin
                sign_ch = CH_MINUS;
                num = (-num) & vmask;
            end
            else if (plus)
                sign_ch = CH_PLUS;
            else if (space)
                sign_ch = CH_SPACE;
        end
        if (sign_ch != CH_NONE)
            fixed = 1;
        if (alt && radix != 64'd10)
            pfx = (radix == 64'd16) ? 2 : 1;
        fixed += pfx;

        do
        begin
            digs[nd] = HEX_DIGITS[4'(num % radix)] | lc;
            nd++;
            num = num / radix;
        end
        while (num != 0 && nd < 64);

        width = (fw > 7'd64) ? 64 : int'(fw);
        prec  = int'(md);
        if (prec > 64 - fixed)
            prec = 64 - fixed;
        if (prec < nd)
            prec = nd;
        pad = width - fixed - prec;
        if (pad < 0)
            pad = 0;

        if (!left && !zpad)
        begin
            repeat (pad) text.push_back(CH_SPACE);
            pad = 0;
        end
        if (sign_ch != CH_NONE)
            text.push_back(sign_ch);
        if (pfx > 0)
            text.push_back(CH_ZERO);
        if (pfx == 2)
            text.push_back(CH_X | lc);
        if (!left)
        begin
            repeat (pad) text.push_back(CH_ZERO);
            pad = 0;
        end
        repeat (prec - nd) text.push_back(CH_ZERO);
        for (int i = nd - 1; i >= 0; i--)
            text.push_back(digs[i]);
        repeat (pad) text.push_back(CH_SPACE);

        n = (text.size() > 64) ? 64 : text.size();
        for (int i = 0; i < n; i++)
        begin
            beat.ch   = text[i];
            beat.last = (i == n - 1);
            expected_text.push_back(beat);
        end
    endfunction

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n)
        begin
            // A character can never come from the item taken at this same edge,
            // so the output side is checked before the new text is queued.
            if (char_valid && !char_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected char beat: expected none, got %h last %b",
                             $time, out_char, last_char);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (out_char !== want.ch)
                    begin
                        errors++;
                        $display("%0t: out_char mismatch: expected %h, got %h",
                                 $time, want.ch, out_char);
                    end
                    if (last_char !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_char mismatch: expected %b, got %b",
                                 $time, want.last, last_char);
                    end
                end
            end
            if (item_valid && !item_stall)
                format_item(64'(value), base_select, min_width, min_digits, signed_mode,
                            left_justify, zero_pad, plus_sign, space_sign, alt_prefix,
                            lower_case);
            pending = expected_text.size();
        end
    end

endmodule

/* tb/integer_to_ascii_formatter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer-to-ASCII formatter test
// Drives directed corner items and then random format requests into the
// formatter with random gaps, output back-pressure and one long hold-off,
// and reports the verdict from the character checker.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
    import itaf_pkg::*;

    localparam int VALUE_WIDTH = 64;

    localparam logic [1:0] BSEL_HEX   = BASE_HEX;
    localparam logic [1:0] BSEL_SPARE = 2'd3;

    // Flag bits in the order signed, left, zero, plus, space, alt, lower.
    localparam logic [6:0] FL_NONE   = 7'b0000000;
    localparam logic [6:0] FL_SIGNED = 7'b1000000;
    localparam logic [6:0] FL_LEFT   = 7'b0100000;
    localparam logic [6:0] FL_ZERO   = 7'b0010000;
    localparam logic [6:0] FL_PLUS   = 7'b0001000;
    localparam logic [6:0] FL_SPACE  = 7'b0000100;
    localparam logic [6:0] FL_ALT    = 7'b0000010;
    localparam logic [6:0] FL_LOWER  = 7'b0000001;

    localparam logic [63:0] V_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] V_MIN_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] V_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  base_select;
        logic [6:0]  min_width;
        logic [5:0]  min_digits;
        logic [6:0]  flags;
    } fmt_req_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    logic [VALUE_WIDTH-1:0] value        = '0;
    logic [1:0]             base_select  = '0;
    logic [6:0]             min_width    = '0;
    logic [5:0]             min_digits   = '0;
    logic                   signed_mode  = 1'b0;
    logic                   left_justify = 1'b0;
    logic                   zero_pad     = 1'b0;
    logic                   plus_sign    = 1'b0;
    logic                   space_sign   = 1'b0;
    logic                   alt_prefix   = 1'b0;
    logic                   lower_case   = 1'b0;
    logic                   char_valid;
    logic                   char_stall   = 1'b0;
    logic [7:0]             out_char;
    logic                   last_char;

    int errors;
    int pending;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    bit long_hold_req = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    integer_to_ascii_formatter #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .base_select  (base_select),
        .min_width    (min_width),
        .min_digits   (min_digits),
        .signed_mode  (signed_mode),
        .left_justify (left_justify),
        .zero_pad     (zero_pad),
        .plus_sign    (plus_sign),
        .space_sign   (space_sign),
        .alt_prefix   (alt_prefix),
        .lower_case   (lower_case),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .out_char     (out_char),
        .last_char    (last_char)
    );

    itaf_char_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) char_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .base_select  (base_select),
        .min_width    (min_width),
        .min_digits   (min_digits),
        .signed_mode  (signed_mode),
        .left_justify (left_justify),
        .zero_pad     (zero_pad),
        .plus_sign    (plus_sign),
        .space_sign   (space_sign),
        .alt_prefix   (alt_prefix),
        .lower_case   (lower_case),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .out_char     (out_char),
        .last_char    (last_char),
        .errors       (errors),
        .pending      (pending)
    );

    function automatic fmt_req_t make_req(
        input logic [63:0] v,
        input logic [1:0]  b,
        input logic [6:0]  w,
        input logic [5:0]  p,
        input logic [6:0]  f
    );
        fmt_req_t r;
        r.value       = v;
        r.base_select = b;
        r.min_width   = w;
        r.min_digits  = p;
        r.flags       = f;
        return r;
    endfunction

    // Called just after a rising edge; returns at the edge where the beat is taken.
    task automatic send_format(input fmt_req_t r);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        value       <= r.value[VALUE_WIDTH-1:0];
        base_select <= r.base_select;
        min_width   <= r.min_width;
        min_digits  <= r.min_digits;
        {signed_mode, left_justify, zero_pad, plus_sign, space_sign, alt_prefix,
         lower_case} <= r.flags;
        item_valid  <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Output side: short random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                stall_left    = 400;
                long_hold_req = 1'b0;
            end
            else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
                stall_left = $urandom_range(1, 3);
            char_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        fmt_req_t r;
        logic [63:0] rnd;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_pct   = 15;
        rx_stall_pct = 15;

        // Zero value, with and without a prefix.
        send_format(make_req(64'd0, BSEL_DEC, 7'd0, 6'd0, FL_NONE));
        send_format(make_req(64'd0, BSEL_OCT, 7'd0, 6'd0, FL_ALT));
        send_format(make_req(64'd0, BSEL_HEX, 7'd0, 6'd0, FL_ALT | FL_LOWER));
        send_format(make_req(64'd0, BSEL_DEC, 7'd0, 6'd0, FL_SIGNED | FL_PLUS));
        // All ones in every base.
        send_format(make_req(V_MAX, BSEL_OCT, 7'd0, 6'd0, FL_ALT));
        send_format(make_req(V_MAX, BSEL_DEC, 7'd0, 6'd0, FL_NONE));
        send_format(make_req(V_MAX, BSEL_HEX, 7'd0, 6'd0, FL_NONE));
        // Signed extremes and sign flags.
        send_format(make_req(V_MIN_NEG, BSEL_DEC, 7'd0, 6'd0, FL_SIGNED));
        send_format(make_req(V_MAX, BSEL_DEC, 7'd0, 6'd0, FL_SIGNED | FL_PLUS));
        send_format(make_req(V_MAX_POS, BSEL_DEC, 7'd0, 6'd0, FL_SIGNED | FL_PLUS));
        send_format(make_req(64'd42, BSEL_DEC, 7'd8, 6'd0, FL_SIGNED | FL_SPACE));
        send_format(make_req(64'd42, BSEL_DEC, 7'd8, 6'd0,
                             FL_SIGNED | FL_PLUS | FL_SPACE | FL_ZERO));
        // Sign flags are ignored outside signed mode.
        send_format(make_req(64'd42, BSEL_DEC, 7'd8, 6'd0, FL_PLUS | FL_SPACE));
        // The spare base code formats as hex; the alternate flag does nothing in decimal.
        send_format(make_req(64'd255, BSEL_SPARE, 7'd0, 6'd0, FL_ALT));
        send_format(make_req(64'd255, BSEL_DEC, 7'd6, 6'd0, FL_ALT));
        // Width saturation and left justification cancelling zero padding.
        send_format(make_req(64'hDEAD_BEEF, BSEL_HEX, 7'd127, 6'd0, FL_ALT | FL_ZERO));
        send_format(make_req(64'hDEAD_BEEF, BSEL_HEX, 7'd64, 6'd0,
                             FL_LEFT | FL_ZERO | FL_LOWER | FL_ALT));
        // Precision saturation around sign and prefix.
        send_format(make_req(64'd1, BSEL_HEX, 7'd0, 6'd63, FL_SIGNED | FL_PLUS | FL_ALT));
        send_format(make_req(V_MAX, BSEL_OCT, 7'd0, 6'd60, FL_ALT));
        // Content wider than the field is never cut; then mixed width, precision and flags.
        send_format(make_req(64'd123456789, BSEL_DEC, 7'd3, 6'd0, FL_NONE));
        send_format(make_req(64'd7, BSEL_OCT, 7'd20, 6'd5, FL_ZERO));
        send_format(make_req(64'd5, BSEL_DEC, 7'd10, 6'd3, FL_LEFT | FL_SIGNED | FL_SPACE));
        send_format(make_req(64'hABCDEF, BSEL_HEX, 7'd12, 6'd8, FL_LOWER));
        send_format(make_req(V_MAX, BSEL_HEX, 7'd127, 6'd63,
                             FL_SIGNED | FL_LEFT | FL_ZERO | FL_PLUS | FL_SPACE |
                             FL_ALT | FL_LOWER));

        for (int i = 0; i < 96; i++)
        begin
            if (i < 24)
            begin
                tx_gap_pct   = 20;
                rx_stall_pct = 20;
            end
            else if (i < 48)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 30;
                // The receiver backs off long enough for the input side to fill up.
                if (i == 24)
                    long_hold_req = 1'b1;
            end
            else if (i < 64)
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            else if (i < 80)
            begin
                tx_gap_pct   = 40;
                rx_stall_pct = 40;
            end
            else
            begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end

            rnd = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: rnd = rnd >> $urandom_range(0, 63);
                1: rnd = 64'($urandom_range(0, 20));
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: rnd = 64'd0;
                        1: rnd = V_MAX;
                        2: rnd = V_MIN_NEG;
                        default: rnd = V_MAX_POS;
                    endcase
                end
                3: rnd = ~(rnd >> $urandom_range(0, 63));
                default: ;
            endcase
            r.value       = rnd;
            r.base_select = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                0, 1, 2:          r.min_width = 7'($urandom_range(0, 127));
                3, 4, 5, 6, 7:    r.min_width = 7'($urandom_range(0, 64));
                default:          r.min_width = 7'($urandom_range(0, 24));
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:          r.min_digits = 6'($urandom_range(0, 63));
                3, 4, 5, 6, 7:    r.min_digits = 6'($urandom_range(0, 30));
                default:          r.min_digits = 6'($urandom_range(0, 12));
            endcase
            r.flags = 7'($urandom);
            send_format(r);
        end
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (64) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
